FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DWRQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DWRQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/dwrq_pkg.sv
package dwrq_pkg;

	localparam int POT_W    = 3;
	localparam int MOIST_W  = 10;
	localparam int BTN_W    = 5;
	localparam int BYTE_W   = 8;
	localparam int NUM_POTS = 4;

	localparam logic [MOIST_W-1:0] MOIST_LOW_RST  = 10'd700;
	localparam logic [MOIST_W-1:0] MOIST_HIGH_RST = 10'd950;

	localparam logic [BYTE_W-1:0] LINK_READY = 8'hFF;
	localparam logic [BYTE_W-1:0] LINK_HOME  = 8'h55;
	localparam logic [BYTE_W-1:0] LINK_ERROR = 8'h0F;

	localparam int CFG_IDX_W = 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MOISTURE_LOW  = 1'b0,
		CFG_MOISTURE_HIGH = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		REQ_MOISTURE = 2'd0,
		REQ_BUTTON   = 2'd1,
		REQ_LINK     = 2'd2
	} req_kind_t;

	typedef enum logic [1:0] {
		PH_START   = 2'd0,
		PH_WAIT    = 2'd1,
		PH_PRESSED = 2'd2
	} btn_phase_t;

	typedef enum logic [1:0] {
		LS_NORMAL = 2'd0,
		LS_HOME   = 2'd1,
		LS_HALT   = 2'd2
	} link_phase_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_COMMIT = 2'd2
	} seq_state_t;

	typedef logic [POT_W-1:0] pot_t;

	// Token that walks the cell row during the duplicate scan.
	typedef struct packed {
		pot_t pot;
		logic hit;
	} scan_tok_t;

	// Controls common to every cell.
	typedef struct packed {
		logic shift;
		pot_t wr_pot;
	} cell_ctl_t;

	// Lowest pot button held low, 0 when none.
	function automatic pot_t first_pressed(input logic [BTN_W-1:0] lev);
		pot_t res;
		res = '0;
		for (int k = BTN_W - 1; k >= 1; k--) begin
			if (!lev[k]) begin
				res = POT_W'(k);
			end
		end
		return res;
	endfunction

endpackage

FILE: src/dwrq_if.sv
interface dwrq_req_if;
	import dwrq_pkg::*;

	logic                valid;
	logic                ready;
	logic [1:0]          req_type;
	logic [POT_W-1:0]    pot_id;
	logic [MOIST_W-1:0]  moisture;
	logic [BTN_W-1:0]    button_levels;
	logic [BYTE_W-1:0]   link_byte;

	modport source (output valid, req_type, pot_id, moisture, button_levels, link_byte,
		input ready);
	modport sink (input valid, req_type, pot_id, moisture, button_levels, link_byte,
		output ready);
endinterface

interface dwrq_rsp_if;
	import dwrq_pkg::*;

	logic             valid;
	logic             ready;
	logic             send_valid;
	logic [POT_W-1:0] send_pot;
	logic [POT_W-1:0] working_pot;
	logic [2:0]       queue_count;
	logic             display_mode;
	logic [1:0]       link_status;

	modport source (output valid, send_valid, send_pot, working_pot, queue_count,
		display_mode, link_status, input ready);
	modport sink (input valid, send_valid, send_pot, working_pot, queue_count,
		display_mode, link_status, output ready);
endinterface

FILE: src/dwrq_cell.sv
module dwrq_cell (
	input  logic                  clk,
	input  dwrq_pkg::scan_tok_t   tok_in,
	output dwrq_pkg::scan_tok_t   tok_out,
	input  dwrq_pkg::cell_ctl_t   ctl,
	input  logic                  wr_sel,
	input  logic                  occ,
	input  dwrq_pkg::pot_t        next_slot,
	output dwrq_pkg::pot_t        slot
);
	import dwrq_pkg::*;

	scan_tok_t tok_q;
	pot_t      slot_q;

	// Compare the passing token against this slot, only when occupied.
	always_ff @(posedge clk) begin
		tok_q.pot <= tok_in.pot;
		tok_q.hit <= tok_in.hit | (occ & (slot_q == tok_in.pot));
	end

	// Write takes priority; shift towards the head on dequeue.
	always_ff @(posedge clk) begin
		if (wr_sel) begin
			slot_q <= ctl.wr_pot;
		end else if (ctl.shift) begin
			slot_q <= next_slot;
		end
	end

	assign tok_out = tok_q;
	assign slot    = slot_q;
endmodule

FILE: src/dedup_watering_request_queue_unit.sv
// Channel | Dir | Payload                                            | Handshake
// req     | in  | req_type, pot_id, moisture, button_levels, link_byte | valid/ready
// rsp     | out | send_valid, send_pot, working_pot, queue_count,     | valid/ready
//         |     | display_mode, link_status                           |
// cfg     | in  | cfg_index, cfg_wdata                                | cfg_we only
//
// Each request is accepted in idle, then the duplicate-scan token walks the row of
// cells (one cell per cycle), and the request then commits.
// Reset (arst_n low) empties the queue, clears the worked-on pot, starts the button
// machine, selects queue display and normal link status; thresholds return to 700/950.
// A stalled rsp holds its result; the next request is still accepted and scanned,
// and waits in commit until the result register frees.
module dedup_watering_request_queue_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [dwrq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dwrq_pkg::MOIST_W-1:0]        cfg_wdata,
	dwrq_req_if.sink                            req,
	dwrq_rsp_if.source                          rsp
);
	import dwrq_pkg::*;

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Sequencer
	seq_state_t state_q, state_d;
	logic [IDX_W-1:0] scan_cnt_q;
	logic hit_q;
	logic scan_last;
	logic commit_en;
	logic out_free;

	// Captured request
	logic [1:0]         type_q;
	pot_t               pot_q;
	pot_t               cand_q;
	logic [MOIST_W-1:0] moist_q;
	logic [BTN_W-1:0]   lev_q;
	logic [BYTE_W-1:0]  byte_q;

	// Configuration
	logic [MOIST_W-1:0] moist_low_q;
	logic [MOIST_W-1:0] moist_high_q;

	// Architectural state
	logic [CNT_W-1:0] count_q, count_d;
	pot_t             cur_q, cur_d;
	btn_phase_t       btn_q, btn_d;
	logic             show_q, show_d;
	link_phase_t      link_q, link_d;

	// Commit decisions
	logic do_push;
	logic do_pop;
	logic full;
	pot_t head_pot;

	// Result register
	logic             rsp_valid_q;
	logic             send_valid_q;
	pot_t             send_pot_q;
	pot_t             working_pot_q;
	logic [2:0]       queue_count_q;
	logic             display_mode_q;
	logic [1:0]       link_status_q;

	// Cell row
	scan_tok_t tok_head;
	scan_tok_t tok_chain [QUEUE_DEPTH+1];
	pot_t      slots     [QUEUE_DEPTH];
	cell_ctl_t cell_ctl;

	// Inject the candidate pot at the head of the row: a button request checks
	// the lowest pressed pot button, a moisture sample its own pot.
	always_comb begin
		tok_head.hit = 1'b0;
		if (req.req_type == REQ_BUTTON) begin
			tok_head.pot = first_pressed(req.button_levels);
		end else begin
			tok_head.pot = req.pot_id;
		end
	end

	assign tok_chain[0] = tok_head;

	assign cell_ctl.shift  = commit_en & do_pop;
	assign cell_ctl.wr_pot = cand_q;

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic cell_occ;
		logic cell_wr;
		pot_t cell_next;

		assign cell_occ  = (count_q > CNT_W'(i));
		assign cell_wr   = commit_en & do_push & (count_q == CNT_W'(i));
		assign cell_next = (i == QUEUE_DEPTH - 1) ? '0 : slots[(i + 1) % QUEUE_DEPTH];

		dwrq_cell u_cell (
			.clk       (clk),
			.tok_in    (tok_chain[i]),
			.tok_out   (tok_chain[i+1]),
			.ctl       (cell_ctl),
			.wr_sel    (cell_wr),
			.occ       (cell_occ),
			.next_slot (cell_next),
			.slot      (slots[i])
		);
	end

	assign head_pot  = slots[0];
	assign scan_last = (scan_cnt_q == IDX_W'(QUEUE_DEPTH - 1));
	assign out_free  = ~rsp_valid_q | rsp.ready;

	// Next state of the sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_last) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs
	always_comb begin
		req.ready = 1'b0;
		commit_en = 1'b0;
		case (state_q)
			ST_IDLE:   req.ready = 1'b1;
			ST_COMMIT: commit_en = out_free;
			default: begin
				req.ready = 1'b0;
				commit_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SCAN) begin
				scan_cnt_q <= scan_last ? '0 : scan_cnt_q + 1'b1;
			end else begin
				scan_cnt_q <= '0;
			end
		end
	end

	// Capture the request and, at the end of the walk, the scan verdict.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			type_q  <= req.req_type;
			pot_q   <= req.pot_id;
			cand_q  <= tok_head.pot;
			moist_q <= req.moisture;
			lev_q   <= req.button_levels;
			byte_q  <= req.link_byte;
		end
		if (state_q == ST_SCAN && scan_last) begin
			hit_q <= tok_chain[QUEUE_DEPTH].hit;
		end
	end

	// Threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			moist_low_q  <= MOIST_LOW_RST;
			moist_high_q <= MOIST_HIGH_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MOISTURE_LOW:  moist_low_q  <= cfg_wdata;
				CFG_MOISTURE_HIGH: moist_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign full = (count_q >= CNT_W'(QUEUE_DEPTH));

	// Work out the effect of the captured request on the queue and the
	// button and link machines.
	always_comb begin
		count_d = count_q;
		cur_d   = cur_q;
		btn_d   = btn_q;
		show_d  = show_q;
		link_d  = link_q;
		do_push = 1'b0;
		do_pop  = 1'b0;
		case (link_q)
			LS_NORMAL: begin
				case (type_q)
					REQ_MOISTURE: begin
						if (pot_q != '0 && pot_q <= POT_W'(NUM_POTS) &&
							moist_q > moist_low_q && moist_q < moist_high_q) begin
							do_push = ~full & ~hit_q;
						end
					end
					REQ_BUTTON: begin
						case (btn_q)
							PH_START: btn_d = PH_WAIT;
							PH_WAIT: begin
								// Hold in wait while the queue is full.
								if (!full) begin
									if (!lev_q[0]) begin
										show_d = ~show_q;
										btn_d  = PH_PRESSED;
									end else if (cand_q != '0) begin
										btn_d = PH_PRESSED;
										if (cand_q <= POT_W'(NUM_POTS) && cur_q != cand_q) begin
											do_push = ~hit_q;
										end
									end
								end
							end
							PH_PRESSED: begin
								if (&lev_q) begin
									btn_d = PH_WAIT;
								end
							end
							default: btn_d = PH_START;
						endcase
					end
					REQ_LINK: begin
						if (byte_q == LINK_READY) begin
							if (count_q != '0) begin
								do_pop = 1'b1;
								cur_d  = head_pot;
							end
						end else if (byte_q == LINK_HOME) begin
							cur_d  = '0;
							link_d = LS_HOME;
						end else if (byte_q == LINK_ERROR) begin
							link_d = LS_HALT;
						end
					end
					default: ;
				endcase
			end
			LS_HOME: begin
				if (type_q == REQ_LINK) begin
					if (byte_q == LINK_READY) begin
						link_d = LS_NORMAL;
					end else if (byte_q == LINK_ERROR) begin
						link_d = LS_HALT;
					end
				end
			end
			default: ;
		endcase
		if (do_push) begin
			count_d = count_q + 1'b1;
		end else if (do_pop) begin
			count_d = count_q - 1'b1;
		end
	end

	// Advance architectural state on commit only.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cur_q   <= '0;
			btn_q   <= PH_START;
			show_q  <= 1'b1;
			link_q  <= LS_NORMAL;
		end else if (commit_en) begin
			count_q <= count_d;
			cur_q   <= cur_d;
			btn_q   <= btn_d;
			show_q  <= show_d;
			link_q  <= link_d;
		end
	end

	// Result register: load on commit, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit_en) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			send_valid_q   <= do_pop;
			send_pot_q     <= do_pop ? head_pot : '0;
			working_pot_q  <= cur_d;
			queue_count_q  <= 3'(count_d);
			display_mode_q <= show_d;
			link_status_q  <= link_d;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.send_valid   = send_valid_q;
	assign rsp.send_pot     = send_pot_q;
	assign rsp.working_pot  = working_pot_q;
	assign rsp.queue_count  = queue_count_q;
	assign rsp.display_mode = display_mode_q;
	assign rsp.link_status  = link_status_q;
endmodule

FILE: src/dwrq_checker.sv
`include "assert_macros.svh"

module dwrq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic                       send_valid,
	input logic [dwrq_pkg::POT_W-1:0] send_pot,
	input logic [dwrq_pkg::POT_W-1:0] working_pot,
	input logic [1:0]                 link_status
);
	import dwrq_pkg::*;

	// A dispatch names a real pot and makes it the worked-on pot.
	`DWRQ_ASSERT_NOW(a_send_pot_nonzero, clk, arst_n, rsp_valid && send_valid, send_pot != '0, "dispatch without a pot")
	`DWRQ_ASSERT_NOW(a_send_sets_working, clk, arst_n, rsp_valid && send_valid, working_pot == send_pot, "dispatched pot not marked as worked on")
	// Going home clears the worked-on pot and nothing dispatches meanwhile.
	`DWRQ_ASSERT_NOW(a_home_no_pot, clk, arst_n, rsp_valid && link_status == LS_HOME, working_pot == '0 && !send_valid, "worked-on pot set while going home")
	`DWRQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "stalled result dropped")
endmodule

bind dedup_watering_request_queue_unit dwrq_checker u_dwrq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.send_valid  (rsp.send_valid),
	.send_pot    (rsp.send_pot),
	.working_pot (rsp.working_pot),
	.link_status (rsp.link_status)
);

FILE: tb/watering_queue_checker.sv
`timescale 1ns / 100ps

module watering_queue_checker #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dwrq_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dwrq_pkg::MOIST_W-1:0]  cfg_wdata,
	dwrq_req_if                           req,
	dwrq_rsp_if                           rsp,
	output int                            mismatches,
	output int                            open_results
);
	import dwrq_pkg::*;

	typedef struct packed {
		logic        send_valid;
		pot_t        send_pot;
		pot_t        working_pot;
		logic [2:0]  queue_count;
		logic        display_mode;
		link_phase_t link_status;
	} watering_status_t;

	logic [MOIST_W-1:0] thr_low;
	logic [MOIST_W-1:0] thr_high;
	pot_t               slots [QUEUE_DEPTH];
	int                 head;
	int                 tail;
	int                 fill;
	pot_t               cur_pot;
	btn_phase_t         btn_state;
	logic               show_q;
	link_phase_t        link_state;
	watering_status_t   expected_status [$];

	// Scan occupied slots only, oldest first.
	function automatic logic holds_pot(pot_t pot);
		for (int i = 0; i < fill; i++) begin
			if (slots[(head + i) % QUEUE_DEPTH] == pot) begin
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void enqueue_pot(pot_t pot);
		if (fill >= QUEUE_DEPTH || holds_pot(pot)) begin
			return;
		end
		tail = (tail + 1) % QUEUE_DEPTH;
		slots[tail] = pot;
		fill++;
	endfunction

	function automatic void step_buttons(logic [BTN_W-1:0] lev);
		logic found;
		found = 1'b0;
		case (btn_state)
			PH_START: begin
				btn_state = PH_WAIT;
			end
			PH_WAIT: begin
				// A full queue holds the machine in wait.
				if (fill < QUEUE_DEPTH) begin
					if (!lev[0]) begin
						show_q = ~show_q;
						btn_state = PH_PRESSED;
					end else begin
						for (int k = 1; k < BTN_W; k++) begin
							if (!found && !lev[k]) begin
								found = 1'b1;
								btn_state = PH_PRESSED;
								if (k <= NUM_POTS && cur_pot != POT_W'(k)) begin
									enqueue_pot(POT_W'(k));
								end
							end
						end
					end
				end
			end
			PH_PRESSED: begin
				if (lev == '1) begin
					btn_state = PH_WAIT;
				end
			end
			default: begin
				btn_state = PH_START;
			end
		endcase
	endfunction

	function automatic watering_status_t apply_request(logic [1:0] kind, pot_t pot,
			logic [MOIST_W-1:0] moist, logic [BTN_W-1:0] lev, logic [BYTE_W-1:0] lbyte);
		watering_status_t st;
		st = '0;
		if (link_state == LS_NORMAL) begin
			case (kind)
				REQ_MOISTURE: begin
					if (pot >= 1 && pot <= NUM_POTS && moist > thr_low && moist < thr_high) begin
						enqueue_pot(pot);
					end
				end
				REQ_BUTTON: begin
					step_buttons(lev);
				end
				REQ_LINK: begin
					if (lbyte == LINK_READY) begin
						if (fill > 0) begin
							st.send_valid = 1'b1;
							st.send_pot = slots[head];
							head = (head + 1) % QUEUE_DEPTH;
							fill--;
							cur_pot = st.send_pot;
						end
					end else if (lbyte == LINK_HOME) begin
						cur_pot = '0;
						link_state = LS_HOME;
					end else if (lbyte == LINK_ERROR) begin
						link_state = LS_HALT;
					end
				end
				default: begin
				end
			endcase
		end else if (link_state == LS_HOME && kind == REQ_LINK) begin
			if (lbyte == LINK_READY) begin
				link_state = LS_NORMAL;
			end else if (lbyte == LINK_ERROR) begin
				link_state = LS_HALT;
			end
		end
		st.working_pot = cur_pot;
		st.queue_count = 3'(fill);
		st.display_mode = show_q;
		st.link_status = link_state;
		return st;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		watering_status_t want;
		if (!arst_n) begin
			thr_low = MOIST_LOW_RST;
			thr_high = MOIST_HIGH_RST;
			head = 0;
			tail = QUEUE_DEPTH - 1;
			fill = 0;
			cur_pot = '0;
			btn_state = PH_START;
			show_q = 1'b1;
			link_state = LS_NORMAL;
			expected_status.delete();
			mismatches = 0;
			open_results = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MOISTURE_LOW:  thr_low = cfg_wdata;
					CFG_MOISTURE_HIGH: thr_high = cfg_wdata;
					default: begin
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_status.size() == 0) begin
					$error("result with nothing expected: send_pot %0d, queue_count %0d",
						rsp.send_pot, rsp.queue_count);
					mismatches++;
				end else begin
					want = expected_status.pop_front();
					check_field("send_valid", want.send_valid, rsp.send_valid);
					check_field("send_pot", want.send_pot, rsp.send_pot);
					check_field("working_pot", want.working_pot, rsp.working_pot);
					check_field("queue_count", want.queue_count, rsp.queue_count);
					check_field("display_mode", want.display_mode, rsp.display_mode);
					check_field("link_status", want.link_status, rsp.link_status);
				end
			end
			if (req.valid && req.ready) begin
				expected_status.push_back(apply_request(req.req_type, req.pot_id, req.moisture,
					req.button_levels, req.link_byte));
			end
			open_results = expected_status.size();
		end
	end

endmodule

FILE: tb/tb_dedup_watering_request_queue_unit.sv
`timescale 1ns / 100ps

module tb_dedup_watering_request_queue_unit;
	import dwrq_pkg::*;

	localparam int         QUEUE_DEPTH     = 4;
	// Covers the accept step, one scan step per cell and the commit step.
	localparam int         LATENCY         = QUEUE_DEPTH + 2;
	localparam int         PHASES          = 5;
	localparam int         PHASE_ITEMS     = 160;
	localparam int         RSP_HOLD_CYCLES = 300;
	localparam longint     CYCLE_LIMIT     = 400000;
	// Request type with no meaning: the block must leave its state alone.
	localparam logic [1:0] REQ_UNKNOWN     = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		pot_t               pot;
		logic [MOIST_W-1:0] moist;
		logic [BTN_W-1:0]   lev;
		logic [BYTE_W-1:0]  lbyte;
	} sensor_req_t;

	localparam int REQ_BITS = $bits(sensor_req_t);

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MOIST_W-1:0]   cfg_wdata;
	int                   mismatches;
	int                   open_results;
	longint               cycle_count = 0;
	// Thresholds as last written, used to aim moisture readings into the window.
	logic [MOIST_W-1:0]   thr_low = MOIST_LOW_RST;
	logic [MOIST_W-1:0]   thr_high = MOIST_HIGH_RST;
	logic                 sender_gaps_on;
	logic                 rsp_gaps_on;
	logic                 rsp_hold_req;

	dwrq_req_if req();
	dwrq_rsp_if rsp();

	dedup_watering_request_queue_unit #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	watering_queue_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) status_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.req          (req),
		.rsp          (rsp),
		.mismatches   (mismatches),
		.open_results (open_results)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap(logic on);
		int roll;
		if (!on) begin
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(10, 40);
	endfunction

	// Reading strictly inside the current window, or anything if the window is empty.
	function automatic logic [MOIST_W-1:0] window_moisture();
		if (int'(thr_high) - int'(thr_low) >= 2) begin
			return MOIST_W'($urandom_range(int'(thr_low) + 1, int'(thr_high) - 1));
		end
		return MOIST_W'($urandom);
	endfunction

	// Offer one request from the falling edge and hold it until the block takes it,
	// then idle for a random gap. Valid stays high when the gap is zero.
	task automatic send_req(input sensor_req_t r);
		int gap;
		req.req_type      <= r.kind;
		req.pot_id        <= r.pot;
		req.moisture      <= r.moist;
		req.button_levels <= r.lev;
		req.link_byte     <= r.lbyte;
		req.valid         <= 1'b1;
		do @(posedge clk); while (!req.ready);
		@(negedge clk);
		gap = pick_gap(sender_gaps_on);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Unused fields carry random bits so that the block is seen to ignore them.
	task automatic moisture_req(input pot_t pot, input logic [MOIST_W-1:0] m);
		sensor_req_t r;
		r = REQ_BITS'($urandom);
		r.kind = REQ_MOISTURE;
		r.pot = pot;
		r.moist = m;
		send_req(r);
	endtask

	task automatic button_req(input logic [BTN_W-1:0] lev);
		sensor_req_t r;
		r = REQ_BITS'($urandom);
		r.kind = REQ_BUTTON;
		r.lev = lev;
		send_req(r);
	endtask

	task automatic link_req(input logic [BYTE_W-1:0] b);
		sensor_req_t r;
		r = REQ_BITS'($urandom);
		r.kind = REQ_LINK;
		r.lbyte = b;
		send_req(r);
	endtask

	// Drop valid and hold until every result is back and the pipeline has emptied.
	task automatic drain();
		req.valid <= 1'b0;
		while (open_results != 0) @(negedge clk);
		repeat (LATENCY) @(negedge clk);
	endtask

	// Write both thresholds on consecutive cycles with the enable held high.
	task automatic set_thresholds(input logic [MOIST_W-1:0] lo, input logic [MOIST_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MOISTURE_LOW;
		cfg_wdata <= lo;
		@(negedge clk);
		cfg_index <= CFG_MOISTURE_HIGH;
		cfg_wdata <= hi;
		@(negedge clk);
		cfg_we    <= 1'b0;
		thr_low  = lo;
		thr_high = hi;
	endtask

	// Random request, weighted towards well-formed traffic: readings aimed into the
	// window, button presses followed by releases, and plenty of ready bytes so that
	// the queue both fills and empties. The error byte is kept back for the end,
	// since a halted block ignores everything until reset.
	function automatic sensor_req_t random_request();
		sensor_req_t r;
		int roll;
		r = REQ_BITS'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < 35) begin
			r.kind = REQ_MOISTURE;
			if ($urandom_range(0, 9) != 0) begin
				r.pot = POT_W'($urandom_range(1, NUM_POTS));
			end
			if ($urandom_range(0, 1) == 1) begin
				r.moist = window_moisture();
			end
		end else if (roll < 70) begin
			r.kind = REQ_BUTTON;
			roll = $urandom_range(0, 99);
			if (roll < 40) begin
				r.lev = '1;
			end else if (roll < 85) begin
				r.lev = ~(BTN_W'(1) << $urandom_range(0, BTN_W - 1));
			end
		end else if (roll < 95) begin
			r.kind = REQ_LINK;
			roll = $urandom_range(0, 99);
			if (roll < 50) begin
				r.lbyte = LINK_READY;
			end else if (roll < 62) begin
				r.lbyte = LINK_HOME;
			end else if (r.lbyte == LINK_ERROR) begin
				r.lbyte = LINK_READY;
			end
		end else begin
			r.kind = REQ_UNKNOWN;
		end
		return r;
	endfunction

	// Result side: random stalls, with stretches of none, and a long hold-off
	// whenever the stimulus asks for one.
	initial begin : result_sink
		int stall_left;
		int mode_left;
		rsp.ready   = 1'b0;
		rsp_gaps_on = 1'b1;
		stall_left  = 0;
		mode_left   = 0;
		forever begin
			@(negedge clk);
			if (rsp_hold_req) begin
				rsp.ready <= 1'b0;
				repeat (RSP_HOLD_CYCLES) @(negedge clk);
				rsp_hold_req = 1'b0;
			end else begin
				if (mode_left == 0) begin
					rsp_gaps_on = ($urandom_range(0, 3) != 0);
					mode_left = $urandom_range(50, 250);
				end else begin
					mode_left--;
				end
				if (stall_left > 0) begin
					rsp.ready <= 1'b0;
					stall_left--;
				end else begin
					rsp.ready <= 1'b1;
					stall_left = pick_gap(rsp_gaps_on);
				end
			end
		end
	end

	initial begin : stimulus
		sensor_req_t r;
		int lo;
		int hi;
		req.valid         = 1'b0;
		req.req_type      = REQ_MOISTURE;
		req.pot_id        = '0;
		req.moisture      = '0;
		req.button_levels = '1;
		req.link_byte     = '0;
		cfg_we            = 1'b0;
		cfg_index         = CFG_MOISTURE_LOW;
		cfg_wdata         = '0;
		sender_gaps_on    = 1'b1;
		rsp_hold_req      = 1'b0;
		arst_n            = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, on the reset thresholds 700 and 950.
		button_req(5'h1F);              // leave the start phase
		moisture_req(3'd1, 10'd701);    // just inside the window: queue pot 1
		moisture_req(3'd2, 10'd700);    // on the low threshold: drop
		moisture_req(3'd2, 10'd950);    // on the high threshold: drop
		moisture_req(3'd2, 10'd949);    // queue pot 2
		moisture_req(3'd1, 10'd800);    // pot 1 already waiting: drop
		moisture_req(3'd0, 10'd800);    // pot number below range: ignore
		moisture_req(3'd7, 10'd1023);   // pot number above range, top reading
		moisture_req(3'd3, 10'd0);      // bottom reading
		r = '1;
		r.kind = REQ_UNKNOWN;
		send_req(r);                    // unknown type with every bit set
		button_req(5'h00);              // all held: display toggle wins
		button_req(5'h1F);
		button_req(5'h1D);              // pot 1 button, already queued
		button_req(5'h1F);
		button_req(5'h17);              // queue pot 3
		button_req(5'h1F);
		button_req(5'h0F);              // queue pot 4: queue now full
		button_req(5'h1F);
		button_req(5'h1E);              // full queue holds the buttons in wait
		link_req(8'h00);                // byte with no meaning
		link_req(LINK_READY);           // send pot 1, now being worked on
		button_req(5'h1D);              // pot 1 is being worked on: no request
		button_req(5'h1F);
		repeat (4) link_req(LINK_READY); // empty the queue, then ready on empty
		link_req(LINK_HOME);
		moisture_req(3'd2, 10'd800);    // ignored while going home
		link_req(8'hAA);                // ignored while going home
		link_req(LINK_READY);           // back to normal, nothing sent

		// Random part, one threshold setting per phase.
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase > 0) begin
				drain();
				case (phase)
					1: set_thresholds(10'd0, 10'd1023);
					2: set_thresholds(10'd1023, 10'd0);
					3: set_thresholds(10'd511, 10'd514);
					default: begin
						lo = $urandom_range(0, 900);
						hi = $urandom_range(lo + 2, 1023);
						set_thresholds(MOIST_W'(lo), MOIST_W'(hi));
					end
				endcase
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					sender_gaps_on = ($urandom_range(0, 3) != 0);
				end
				if (n == 60) begin
					if (phase % 2 == 1) begin
						// Hold the result side off and keep offering back to back,
						// so the block fills and stalls its input.
						rsp_hold_req = 1'b1;
						sender_gaps_on = 1'b0;
					end else begin
						drain();
					end
				end
				send_req(random_request());
			end
		end

		// Halt, sometimes from the going-home phase, then show that nothing moves.
		if ($urandom_range(0, 1) == 1) begin
			link_req(LINK_HOME);
		end
		link_req(LINK_ERROR);
		link_req(LINK_READY);
		button_req(5'h1E);
		moisture_req(3'd2, window_moisture());
		link_req(LINK_HOME);

		drain();
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
